// File: sv/bia_pkg.sv
package bia_pkg;

  localparam int ID_W          = 10;
  localparam int ID_COUNT_DEF  = 1024;
  localparam int WORD_BITS_DEF = 32;
  localparam int RESET_WORD0   = 3;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t            command;
    logic [ID_W-1:0] release_id;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic            ok;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_REM,
    ST_REL_RD,
    ST_REL_WR,
    ST_HOLD
  } state_t;

endpackage

// File: sv/bia_ram.sv
module bia_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/bitmap_id_allocator_core.sv
// Channel  Direction  Payload  Handshake
// in_      input      in_t     in_valid / in_stall   (command, release_id)
// out_     output     out_t    out_valid / out_stall (granted_id, ok)
//
// Allocate: one bitmap word checked per cycle, reads pipelined through the RAM
//   read port; the scan ends early when a free bit sits in a low word.
// Release: two-step reciprocal divide, read, write back; a bad id finishes in
//   the accept cycle.
// Reset: a clearing pass writes every bitmap word with in_stall high; word 0
//   comes out as 3.
// A finished transaction sits in the output register; one more may be worked
//   while it waits, and that one then holds until the output frees up.
module bitmap_id_allocator_core
  import bia_pkg::*;
#(
  parameter int ID_COUNT  = ID_COUNT_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int MAP_WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int IDW       = $clog2(MAP_WORDS * WORD_BITS) + 1;
  localparam int LAST_BITS = ID_COUNT - (MAP_WORDS - 1) * WORD_BITS;
  // reciprocal for id / WORD_BITS; estimate is at most one low
  localparam int RK        = 16;
  localparam int RECIP     = (1 << RK) / WORD_BITS;

  localparam logic [WORD_BITS-1:0] LAST_VALID = (LAST_BITS >= WORD_BITS) ? '1 :
    (((WORD_BITS)'(1) << LAST_BITS) - (WORD_BITS)'(1));
  // id slots beyond ID_COUNT in the last word read as taken
  localparam logic [WORD_BITS-1:0] PAD_MASK   = ~LAST_VALID;

  state_t state_r, state_nxt;

  logic [AW-1:0]   clr_r, clr_nxt;
  logic [AW:0]     issue_r, issue_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]   chk_word_r, chk_word_nxt;
  logic [IDW-1:0]  base_r, base_nxt;
  logic [ID_W-1:0] rid_r, rid_nxt;
  logic [AW-1:0]   qest_r, qest_nxt;
  logic [AW-1:0]   word_r, word_nxt;
  logic [BW-1:0]   bit_r, bit_nxt;
  out_t            res_r, res_nxt;
  out_t            out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  // RAM port
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  // scan datapath
  logic [WORD_BITS-1:0] word_eff, low_zero;
  logic [BW-1:0]        fbit;
  logic                 found;
  logic [31:0]          id_ext;
  // release divide
  logic [31:0]          prod, rem32;

  logic  accept, out_free, finish;
  out_t  fin_data;

  bia_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .ADDR_W(AW)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // lowest clear bit: ~w & (w + 1) is one-hot, zero when w is all ones
  always_comb begin
    word_eff = rd_data;
    if (chk_word_r == AW'(MAP_WORDS - 1)) begin
      word_eff = rd_data | PAD_MASK;
    end
    low_zero = ~word_eff & (word_eff + (WORD_BITS)'(1));
    found    = (low_zero != '0);
    fbit     = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_zero[i]) begin
        fbit = fbit | BW'(i);
      end
    end
    id_ext = 32'(base_r) + 32'(fbit);
  end

  assign prod  = 32'(rid_r) * 32'(RECIP);
  assign rem32 = 32'(rid_r) - 32'(qest_r) * 32'(WORD_BITS);

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    issue_nxt    = issue_r;
    chk_vld_nxt  = 1'b0;
    chk_word_nxt = chk_word_r;
    base_nxt     = base_r;
    rid_nxt      = rid_r;
    qest_nxt     = qest_r;
    word_nxt     = word_r;
    bit_nxt      = bit_r;
    res_nxt      = res_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    finish       = 1'b0;
    fin_data     = '0;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = (clr_r == '0) ? (WORD_BITS)'(RESET_WORD0) : '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_ALLOC) begin
            state_nxt = ST_SCAN;
            issue_nxt = '0;
            base_nxt  = '0;
          end else if (32'(in_data.release_id) >= 32'(ID_COUNT)) begin
            // out-of-range release: flagged, map untouched
            finish = 1'b1;
          end else begin
            rid_nxt   = in_data.release_id;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_SCAN: begin
        if (issue_r < (AW + 1)'(MAP_WORDS)) begin
          rd_en        = 1'b1;
          rd_addr      = issue_r[AW-1:0];
          issue_nxt    = issue_r + (AW + 1)'(1);
          chk_vld_nxt  = 1'b1;
          chk_word_nxt = issue_r[AW-1:0];
        end
        if (chk_vld_r) begin
          if (found) begin
            wr_en               = 1'b1;
            wr_addr             = chk_word_r;
            wr_data             = rd_data | low_zero;
            finish              = 1'b1;
            fin_data.granted_id = id_ext[ID_W-1:0];
            fin_data.ok         = 1'b1;
          end else if (chk_word_r == AW'(MAP_WORDS - 1)) begin
            finish = 1'b1;
          end else begin
            base_nxt = base_r + IDW'(WORD_BITS);
          end
        end
      end
      ST_DIV: begin
        qest_nxt  = AW'(prod >> RK);
        state_nxt = ST_REM;
      end
      ST_REM: begin
        if (rem32 >= 32'(WORD_BITS)) begin
          word_nxt = qest_r + AW'(1);
          bit_nxt  = BW'(rem32 - 32'(WORD_BITS));
        end else begin
          word_nxt = qest_r;
          bit_nxt  = BW'(rem32);
        end
        state_nxt = ST_REL_RD;
      end
      ST_REL_RD: begin
        rd_en     = 1'b1;
        rd_addr   = word_r;
        state_nxt = ST_REL_WR;
      end
      ST_REL_WR: begin
        wr_en       = 1'b1;
        wr_addr     = word_r;
        wr_data     = rd_data & ~((WORD_BITS)'(1) << bit_r);
        finish      = 1'b1;
        fin_data.ok = 1'b1;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // result goes straight out when the output register is free, else parks
    if (finish) begin
      if (out_free) begin
        state_nxt = ST_IDLE;
      end else begin
        res_nxt   = fin_data;
        state_nxt = ST_HOLD;
      end
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (finish && out_free) begin
      out_nxt       = fin_data;
      out_valid_nxt = 1'b1;
    end else if (state_r == ST_HOLD && out_free) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      issue_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_word_r <= chk_word_nxt;
    base_r     <= base_nxt;
    rid_r      <= rid_nxt;
    qest_r     <= qest_nxt;
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  // scan base tracks the word whose data is being checked
  a_scan_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && chk_vld_r) |->
      (32'(base_r) == 32'(chk_word_r) * 32'(WORD_BITS)))
    else $error("scan base out of step with checked word");

  // a grant never lands on padding past the last id
  a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && chk_vld_r && found) |-> (id_ext < 32'(ID_COUNT)))
    else $error("granted id beyond ID_COUNT");

  // divide result recombines to the released id
  a_rel_split: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL_RD) |->
      ((32'(word_r) * 32'(WORD_BITS) + 32'(bit_r) == 32'(rid_r)) &&
       (32'(bit_r) < 32'(WORD_BITS))))
    else $error("release word/bit split wrong");

endmodule
